// ----- sv/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

  localparam int DATA_W = 32;
  localparam int NMOD_W = DATA_W + 1;

  // Register select, taken from paddr[2].
  localparam logic IDX_MODULUS  = 1'b0;
  localparam logic IDX_EXPONENT = 1'b1;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_SQR
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_WAIT,
    ST_BIT,
    ST_MUL_WAIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mm_start;
    op_t  op;
    logic wb_base;
    logic wb_result;
    logic shift_exp;
  } cmd_t;

  typedef struct packed {
    logic mm_done;
    logic exp_lsb;
    logic exp_zero;
  } status_t;

endpackage

// ----- sv/mexp_modmul.sv -----
// Bit-serial modular multiplier: one bit of the left operand per cycle.
module mexp_modmul
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic [NMOD_W-1:0] n,
  output logic [DATA_W-1:0] product,
  output logic              done
);

  localparam int CNT_W = $clog2(DATA_W);
  localparam int T_W   = NMOD_W + 1;

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [NMOD_W-1:0] acc;
  logic [NMOD_W-1:0] acc_next;
  logic [DATA_W-1:0] a_sh;
  logic [DATA_W-1:0] b_r;
  logic [T_W-1:0]    t;
  logic [T_W-1:0]    n1;
  logic [T_W-1:0]    n2;
  logic [T_W-1:0]    t_sel;

  // The accumulator stays below n and the addend is at most n, so the
  // doubled sum stays below 3n and two conditional subtractions suffice.
  always_comb begin
    t  = {acc, 1'b0} + (a_sh[DATA_W-1] ? {{(T_W-DATA_W){1'b0}}, b_r} : '0);
    n1 = {1'b0, n};
    n2 = {n, 1'b0};
    if (t >= n2) begin
      t_sel = t - n2;
    end else if (t >= n1) begin
      t_sel = t - n1;
    end else begin
      t_sel = t;
    end
    acc_next = t_sel[NMOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_r  <= b;
    end else if (run) begin
      acc  <= acc_next;
      a_sh <= {a_sh[DATA_W-2:0], 1'b0};
    end
  end

  assign product = acc[DATA_W-1:0];

endmodule

// ----- sv/mexp_datapath.sv -----
// Datapath: operand registers, exponent shifter and the modular multiplier.
module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int EFF_BITS = 32
)(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] modulus,
  input  logic [DATA_W-1:0] exponent,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0]   value_r;
  logic [NMOD_W-1:0]   n_r;
  logic [DATA_W-1:0]   base_r;
  logic [EFF_BITS-1:0] exp_r;
  logic [DATA_W-1:0]   mm_a;
  logic [DATA_W-1:0]   mm_b;
  logic [DATA_W-1:0]   mm_p;
  logic                mm_done;

  always_comb begin
    case (cmd.op)
      OP_REDUCE: begin
        mm_a = value_r;
        mm_b = DATA_W'(1);
      end
      OP_MUL: begin
        mm_a = result;
        mm_b = base_r;
      end
      OP_SQR: begin
        mm_a = base_r;
        mm_b = base_r;
      end
      default: begin
        mm_a = base_r;
        mm_b = base_r;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .n      (n_r),
    .product(mm_p),
    .done   (mm_done)
  );

  // A modulus of zero stands for 2^32.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value;
      n_r     <= {(modulus == '0), modulus};
      result  <= DATA_W'(1);
      exp_r   <= exponent[EFF_BITS-1:0];
    end else begin
      if (cmd.wb_result) result <= mm_p;
      if (cmd.wb_base)   base_r <= mm_p;
      if (cmd.shift_exp) exp_r  <= exp_r >> 1;
    end
  end

  assign status.mm_done  = mm_done;
  assign status.exp_lsb  = exp_r[0];
  assign status.exp_zero = (exp_r == '0);

endmodule

// ----- sv/mexp_ctrl.sv -----
// Controller: sequences reduction, multiplies and squarings for one item.
module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_RED;
      ST_RED:      state_next = ST_RED_WAIT;
      ST_RED_WAIT: if (status.mm_done) state_next = ST_BIT;
      ST_BIT: begin
        if (status.exp_zero) begin
          state_next = ST_DONE;
        end else if (status.exp_lsb) begin
          state_next = ST_MUL_WAIT;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL_WAIT: if (status.mm_done) state_next = ST_SQR;
      ST_SQR: begin
        if (status.exp_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SQR_WAIT;
        end
      end
      ST_SQR_WAIT: if (status.mm_done) state_next = ST_BIT;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // The base is squared only while a higher exponent bit remains.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_RED: begin
        cmd.mm_start = 1'b1;
        cmd.op       = OP_REDUCE;
      end
      ST_RED_WAIT: begin
        cmd.op      = OP_REDUCE;
        cmd.wb_base = status.mm_done;
      end
      ST_BIT: begin
        cmd.op = OP_MUL;
        if (!status.exp_zero) begin
          if (status.exp_lsb) begin
            cmd.mm_start = 1'b1;
          end else begin
            cmd.shift_exp = 1'b1;
          end
        end
      end
      ST_MUL_WAIT: begin
        cmd.op        = OP_MUL;
        cmd.wb_result = status.mm_done;
        cmd.shift_exp = status.mm_done;
      end
      ST_SQR: begin
        cmd.op       = OP_SQR;
        cmd.mm_start = !status.exp_zero;
      end
      ST_SQR_WAIT: begin
        cmd.op      = OP_SQR;
        cmd.wb_base = status.mm_done;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit with its register port.
//
// Raises each accepted value to the exponent register modulo the modulus
// register (a modulus of zero acts as 2^32; an exponent of zero gives 1).
// An item is taken when start is high and busy is low; the residue and its
// low byte appear for one cycle with done, and must be captured then. The
// time per item is set by the bit-serial modular multiplier, which handles
// one multiplier bit per cycle. An item needs one reduction, one multiply
// per set exponent bit and one squaring per bit below the top set bit.
// Busy falls in the cycle after the beat. Registers sit at byte address 0
// (modulus) and 4 (exponent); paddr[2] selects between them.
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = 32
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] value,
  output logic              done,
  output logic [DATA_W-1:0] residue,
  output logic [7:0]        residue_low_byte
);

  localparam int EFF_BITS = (EXP_BITS < DATA_W) ? EXP_BITS : DATA_W;

  logic [DATA_W-1:0] modulus;
  logic [DATA_W-1:0] exponent;
  logic              wr_en;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= DATA_W'(1);
      exponent <= DATA_W'(1);
    end else if (wr_en) begin
      case (paddr[2])
        IDX_MODULUS:  modulus  <= pwdata;
        IDX_EXPONENT: exponent <= pwdata;
        default:      modulus  <= modulus;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      IDX_MODULUS:  prdata = modulus;
      IDX_EXPONENT: prdata = exponent;
      default:      prdata = '0;
    endcase
  end

  mexp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mexp_datapath #(
    .EFF_BITS(EFF_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .value   (value),
    .modulus (modulus),
    .exponent(exponent),
    .result  (residue)
  );

  assign residue_low_byte = residue[7:0];

endmodule

// ----- sv/mexp_checker.sv -----
// Port-level checks for the modular exponentiation unit, bound to the top.
module mexp_checker
  import mexp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [DATA_W-1:0] residue,
  input logic [7:0]        residue_low_byte
);

  // An accepted item keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("unit not busy after accepting an item");

  // A result never follows its item in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done)
    else $error("result beat appeared one cycle after accept");

  // Each result beat ends the item, and the unit is free again.
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("unit still busy after a result beat");

  // A result beat only comes out of a busy unit, with a matching low byte.
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && residue_low_byte == residue[7:0])
    else $error("result beat from an idle unit or with a wrong low byte");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .residue         (residue),
  .residue_low_byte(residue_low_byte)
);

// ----- tb/mexp_result_checker.sv -----
// Result checker for the modular exponentiation unit: tracks the keys, predicts and compares.
module mexp_result_checker
  import mexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              start,
  input  logic              busy,
  input  logic [DATA_W-1:0] value,
  input  logic              done,
  input  logic [DATA_W-1:0] residue,
  input  logic [7:0]        residue_low_byte,
  output int                errors,
  output int                pending,
  output int                residues_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] residue;
    logic [7:0]        low_byte;
  } modexp_result_t;

  modexp_result_t    residue_q[$];
  logic [DATA_W-1:0] key_modulus;
  logic [DATA_W-1:0] key_exponent;
  int                fail_count = 0;
  int                checked_count = 0;

  initial begin
    errors = 0;
    pending = 0;
    residues_checked = 0;
  end

  // A modulus of zero stands for 2^32, so the product just keeps its low word.
  function automatic logic [DATA_W-1:0] mod_fold(input logic [63:0] x,
                                                 input logic [DATA_W-1:0] m);
    logic [63:0] r;
    if (m == '0) return x[DATA_W-1:0];
    r = x % {32'd0, m};
    return r[DATA_W-1:0];
  endfunction

  // Left-to-right square-and-multiply; leading squarings of 1 are harmless.
  function automatic logic [DATA_W-1:0] modexp_predict(input logic [DATA_W-1:0] base_in,
                                                       input logic [DATA_W-1:0] m,
                                                       input logic [DATA_W-1:0] e);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] base;
    if (e == '0) return 32'd1;
    base = mod_fold({32'd0, base_in}, m);
    acc = 32'd1;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      acc = mod_fold({32'd0, acc} * {32'd0, acc}, m);
      if (e[i]) acc = mod_fold({32'd0, acc} * {32'd0, base}, m);
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    modexp_result_t want;
    if (rst) begin
      key_modulus = 32'd1;
      key_exponent = 32'd1;
      residue_q.delete();
    end else begin
      if (done) begin
        if (residue_q.size() == 0) begin
          $error("unexpected result beat: residue %h, residue_low_byte %h",
                 residue, residue_low_byte);
          fail_count++;
        end else begin
          want = residue_q.pop_front();
          checked_count++;
          if (residue !== want.residue) begin
            $error("residue: expected %h, actual %h", want.residue, residue);
            fail_count++;
          end
          if (residue_low_byte !== want.low_byte) begin
            $error("residue_low_byte: expected %h, actual %h", want.low_byte,
                   residue_low_byte);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want.residue = modexp_predict(value, key_modulus, key_exponent);
        want.low_byte = want.residue[7:0];
        residue_q.insert(residue_q.size(), want);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == IDX_MODULUS) key_modulus = pwdata;
          else key_exponent = pwdata;
        end else if (prdata !== ((paddr[2] == IDX_MODULUS) ? key_modulus : key_exponent)) begin
          $error("prdata: expected %h, actual %h",
                 (paddr[2] == IDX_MODULUS) ? key_modulus : key_exponent, prdata);
          fail_count++;
        end
      end
    end
    pending <= residue_q.size();
    errors <= fail_count;
    residues_checked <= checked_count;
  end

endmodule

// ----- tb/modular_exponentiation_unit_tb.sv -----
// Testbench top for the modular exponentiation unit: stimulus, watchdog and verdict.
module modular_exponentiation_unit_tb
  import mexp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int QUIET_CYCLES = 2500;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] value;
  logic              done;
  logic [DATA_W-1:0] residue;
  logic [7:0]        residue_low_byte;

  int errors;
  int pending;
  int residues_checked;
  int items_sent = 0;
  int key_sets = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  modular_exponentiation_unit #(.EXP_BITS(32)) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .value(value),
    .done(done), .residue(residue), .residue_low_byte(residue_low_byte)
  );

  mexp_result_checker i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .value(value),
    .done(done), .residue(residue), .residue_low_byte(residue_low_byte),
    .errors(errors), .pending(pending), .residues_checked(residues_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Reset, any accepted beat, result beat or register access resets the stall count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // A beat is taken at the edge where start is high and busy is low.
  task automatic send_value(input logic [DATA_W-1:0] v);
    int gap;
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 35) gap++;
      if ($urandom_range(0, 9) == 0) gap += $urandom_range(0, 2500);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_keys(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] e);
    wait_idle();
    apb_access(1'b1, IDX_MODULUS, m);
    apb_access(1'b1, IDX_EXPONENT, e);
    apb_access(1'b0, IDX_MODULUS, 32'd0);
    apb_access(1'b0, IDX_EXPONENT, 32'd0);
    key_sets++;
  endtask

  initial begin
    logic [DATA_W-1:0] edge_vals[8];
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] v;
    int n;

    edge_vals = '{32'd0, 32'd1, 32'd65, 32'd3232, 32'd3233, 32'd3234,
                  32'hFFFF_FFFF, 32'h8000_0000};
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset keys give a modulus of one, so every residue is zero.
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    set_keys(32'd3233, 32'd17);
    foreach (edge_vals[i]) send_value(edge_vals[i]);
    // Zero exponent wins over a modulus of one.
    set_keys(32'd1, 32'd0);
    send_value(32'd7);
    set_keys(32'd1, 32'd5);
    send_value(32'd9);
    set_keys(32'd0, 32'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'h1234_5678);
    set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_value(32'hFFFF_FFFE);
    send_value(32'd2);
    set_keys(32'hFFFF_FFFF, 32'd0);
    send_value(32'd0);

    for (int ph = 0; ph < 11; ph++) begin
      steady = 1'b0;
      case (ph)
        0: begin m = $urandom | 32'd1; e = 32'd65537; n = 30; end
        1: begin m = $urandom; e = $urandom_range(0, 255); n = 30; end
        2: begin m = 32'd0; e = $urandom_range(0, 65535); n = 25; end
        3: begin m = $urandom_range(2, 65535); e = $urandom_range(0, 65535); n = 30; end
        4: begin m = $urandom; e = 32'hFFFF_FFFF; n = 8; end
        5: begin m = 32'd1; e = $urandom; n = 10; end
        6: begin m = 32'hFFFF_FFFF; e = $urandom_range(0, 4095); n = 25; end
        7: begin m = $urandom; e = 32'd0; n = 15; end
        8: begin m = $urandom; e = $urandom | 32'h8000_0000; n = 10; end
        9: begin m = $urandom | 32'd1; e = $urandom_range(0, 31); n = 55; steady = 1'b1; end
        default: begin m = 32'd2; e = 32'd3; n = 15; end
      endcase
      set_keys(m, e);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: v = $urandom;
          5, 6:          v = $urandom_range(0, 255);
          7:             v = m - 32'd1 + $urandom_range(0, 2);
          8:             v = $urandom_range(0, 3);
          default:       v = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        send_value(v);
        if (!steady && $urandom_range(0, 24) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (QUIET_CYCLES) @(posedge clk);
    $display("Sent %0d values under %0d key settings; %0d residues compared.",
             items_sent, key_sets, residues_checked);
    $display("Keys spanned unit, zero and all-ones moduli and exponents from zero to all ones.");
    if (errors == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mexp_pkg.sv
sv/mexp_modmul.sv
sv/mexp_datapath.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation_unit.sv
sv/mexp_checker.sv
tb/mexp_result_checker.sv
tb/modular_exponentiation_unit_tb.sv
